### src/xcfp_pkg.sv
// Shared types and constants for the XOR-checked frame parser.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package xcfp_pkg;

  // Default payload buffer depth, in bytes per bank.
  localparam int unsigned MAX_DATA_LEN_DEF = 32;

  // Register reset values.
  localparam logic [7:0] FIRST_HEADER_RST  = 8'h55;
  localparam logic [7:0] SECOND_HEADER_RST = 8'h55;
  localparam logic [7:0] TAIL_BYTE_RST     = 8'hAA;
  localparam logic [6:0] MAX_PAYLOAD_RST   = 7'd32;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_FIRST_HEADER  = 2'd0,
    CFG_SECOND_HEADER = 2'd1,
    CFG_TAIL_BYTE     = 2'd2,
    CFG_MAX_PAYLOAD   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0] first_header;
    logic [7:0] second_header;
    logic [7:0] tail_byte;
    logic [6:0] max_payload;
  } cfg_t;

  // Parser phases of the front end.
  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HEAD2 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4,
    PH_CHECK = 3'd5,
    PH_TAIL  = 3'd6
  } parse_phase_e;

  // Replay states of the back end.
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_READ = 2'd1,
    BK_LOAD = 2'd2
  } back_state_e;

  // One accepted frame, handed from front to back.
  typedef struct packed {
    logic [7:0] command;
    logic [6:0] length;
    logic       bank;
  } frame_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

### src/xcfp_front.sv
// Front end of the frame parser: header/length/checksum/tail state machine.
// Writes payload bytes into the back end's buffer and pushes frame descriptors.
// Depends on xcfp_pkg.
`timescale 1ns / 1ps

module xcfp_front #(
  parameter int unsigned MAX_DATA_LEN = xcfp_pkg::MAX_DATA_LEN_DEF,
  parameter int unsigned IdxW = (MAX_DATA_LEN > 1) ? $clog2(MAX_DATA_LEN) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  xcfp_pkg::cfg_t        cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,
  input  xcfp_pkg::queue_stat_t q_stat_i,
  output logic                  push_o,
  output xcfp_pkg::frame_desc_t desc_o,
  output logic                  wr_en_o,
  output logic [IdxW:0]         wr_addr_o,
  output logic [7:0]            wr_data_o
);
  import xcfp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DATA_LEN + 1);

  parse_phase_e    phase_q, phase_d;
  logic [7:0]      cmd_q, cmd_d;
  logic [6:0]      len_q, len_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [7:0]      xor_q, xor_d;
  logic            bank_q, bank_d;

  logic            accept;
  logic [6:0]      limit;
  logic [CntW-1:0] fill_inc;
  logic            len_ok;
  logic            data_done;

  // Both payload banks are owned by the back end while the queue is full.
  assign in_stall_o = q_stat_i.full;
  assign accept     = in_valid_i & ~q_stat_i.full;

  assign limit     = (cfg_i.max_payload > 7'(MAX_DATA_LEN)) ? 7'(MAX_DATA_LEN)
                                                            : cfg_i.max_payload;
  assign len_ok    = ({1'b0, limit} >= rx_byte_i);
  assign fill_inc  = fill_q + CntW'(1);
  assign data_done = (7'(fill_inc) >= len_q);

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        PH_HUNT1: if (rx_byte_i == cfg_i.first_header) phase_d = PH_HEAD2;
        PH_HEAD2: phase_d = (rx_byte_i == cfg_i.second_header) ? PH_CMD : PH_HUNT1;
        PH_CMD:   phase_d = PH_LEN;
        PH_LEN: begin
          if (rx_byte_i == 8'd0) phase_d = PH_CHECK;
          else if (len_ok)       phase_d = PH_DATA;
          else                   phase_d = PH_HUNT1;
        end
        PH_DATA:  if (data_done) phase_d = PH_CHECK;
        PH_CHECK: phase_d = (rx_byte_i == xor_q) ? PH_TAIL : PH_HUNT1;
        PH_TAIL:  phase_d = PH_HUNT1;
        default:  phase_d = PH_HUNT1;
      endcase
    end
  end

  // Datapath updates and outputs.
  always_comb begin
    cmd_d     = cmd_q;
    len_d     = len_q;
    fill_d    = fill_q;
    xor_d     = xor_q;
    bank_d    = bank_q;
    push_o    = 1'b0;
    wr_en_o   = 1'b0;
    wr_addr_o = {bank_q, fill_q[IdxW-1:0]};
    wr_data_o = rx_byte_i;
    if (accept) begin
      unique case (phase_q)
        PH_CMD: cmd_d = rx_byte_i;
        PH_LEN: begin
          fill_d = '0;
          xor_d  = '0;
          if (rx_byte_i == 8'd0)  len_d = '0;
          else if (len_ok)        len_d = rx_byte_i[6:0];
        end
        PH_DATA: begin
          wr_en_o = 1'b1;
          fill_d  = fill_inc;
          xor_d   = xor_q ^ rx_byte_i;
        end
        PH_TAIL: begin
          if (rx_byte_i == cfg_i.tail_byte) begin
            push_o = 1'b1;
            bank_d = ~bank_q;
          end
        end
        default: ;
      endcase
    end
  end

  assign desc_o = '{command: cmd_q, length: len_q, bank: bank_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      cmd_q   <= '0;
      len_q   <= '0;
      fill_q  <= '0;
      xor_q   <= '0;
      bank_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cmd_q   <= cmd_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      xor_q   <= xor_d;
      bank_q  <= bank_d;
    end
  end

endmodule

### src/xcfp_queue.sv
// Two-entry descriptor queue between the front and back ends.
// One entry per payload bank. Depends on xcfp_pkg.
`timescale 1ns / 1ps

module xcfp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  xcfp_pkg::frame_desc_t desc_i,
  input  logic                  pop_i,
  output xcfp_pkg::frame_desc_t head_o,
  output xcfp_pkg::queue_stat_t stat_o
);
  import xcfp_pkg::*;

  frame_desc_t entry_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  count_q, count_d;

  assign head_o       = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i)      count_d = count_q + 2'd1;
    else if (pop_i && !push_i) count_d = count_q - 2'd1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_d;
    end
  end

endmodule

### src/xcfp_back.sv
// Back end of the frame parser: two-bank payload buffer and result replay.
// Reads one byte per result and holds it in an output register. Depends on xcfp_pkg.
`timescale 1ns / 1ps

module xcfp_back #(
  parameter int unsigned MAX_DATA_LEN = xcfp_pkg::MAX_DATA_LEN_DEF,
  parameter int unsigned IdxW = (MAX_DATA_LEN > 1) ? $clog2(MAX_DATA_LEN) : 1
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [IdxW:0]         wr_addr_i,
  input  logic [7:0]            wr_data_i,
  input  xcfp_pkg::frame_desc_t head_i,
  input  xcfp_pkg::queue_stat_t q_stat_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            command_o,
  output logic [6:0]            payload_length_o,
  output logic [5:0]            byte_index_o,
  output logic [7:0]            payload_byte_o,
  output logic                  has_payload_o,
  output logic                  last_o
);
  import xcfp_pkg::*;

  localparam int unsigned Depth = 2 ** (IdxW + 1);

  logic [7:0]      mem_q [Depth];
  logic [7:0]      rd_data_q;

  back_state_e     state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;

  logic            out_valid_q, out_valid_d;
  logic [7:0]      cmd_q;
  logic [6:0]      len_q;
  logic [5:0]      index_q;
  logic [7:0]      byte_q;
  logic            has_q;
  logic            last_q;

  logic            slot_free;
  logic            empty_frame;
  logic            final_one;
  logic            rd_en;
  logic            load;

  assign slot_free   = ~out_valid_q | ~out_stall_i;
  assign empty_frame = (head_i.length == 7'd0);
  assign final_one   = empty_frame | ((7'(idx_q) + 7'd1) == head_i.length);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) state_d = empty_frame ? BK_LOAD : BK_READ;
      end
      BK_READ: state_d = BK_LOAD;
      BK_LOAD: begin
        if (slot_free) state_d = final_one ? BK_IDLE : BK_READ;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs of the replay sequencer.
  always_comb begin
    rd_en = 1'b0;
    load  = 1'b0;
    pop_o = 1'b0;
    idx_d = idx_q;
    unique case (state_q)
      BK_IDLE: idx_d = '0;
      BK_READ: rd_en = 1'b1;
      BK_LOAD: begin
        if (slot_free) begin
          load  = 1'b1;
          pop_o = final_one;
          idx_d = idx_q + IdxW'(1);
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en)   rd_data_q <= mem_q[{head_i.bank, idx_q}];
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cmd_q   <= head_i.command;
      len_q   <= head_i.length;
      index_q <= empty_frame ? 6'd0 : 6'(idx_q);
      byte_q  <= empty_frame ? 8'd0 : rd_data_q;
      has_q   <= ~empty_frame;
      last_q  <= final_one;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign command_o        = cmd_q;
  assign payload_length_o = len_q;
  assign byte_index_o     = index_q;
  assign payload_byte_o   = byte_q;
  assign has_payload_o    = has_q;
  assign last_o           = last_q;

endmodule

### src/xor_checked_frame_parser.sv
// Top level of the XOR-checked frame parser: configuration registers and wiring.
// Instantiates xcfp_front, xcfp_queue and xcfp_back; depends on xcfp_pkg.
`timescale 1ns / 1ps

// The parser takes one received byte per input transaction and recognizes
// frames of the form first header, second header, command, length, payload,
// XOR of the payload, tail. A length above the smaller of max_payload and
// MAX_DATA_LEN, a wrong second header, a checksum mismatch or a wrong tail
// drops the frame, and hunting for the first header starts with the next
// byte. Input bytes are taken at one per clock while in_stall_o is low. An
// accepted frame is replayed from a payload buffer as one output transaction
// per payload byte (last set on the final one), or as a single empty
// transaction for a zero-length frame. Each payload byte is read from the
// buffer into a registered read (BK_READ), then loaded into the output
// registers (BK_LOAD); an empty frame skips the read. The buffer has two
// banks, so one frame can be received while the previous one is replayed;
// input stalls whenever two accepted frames hold both banks, until the older
// one has been fully replayed. There is no clearing pass after reset.
// Configuration writes must be made while the block is idle.

module xor_checked_frame_parser #(
  parameter int unsigned MAX_DATA_LEN = xcfp_pkg::MAX_DATA_LEN_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] command_o,
  output logic [6:0] payload_length_o,
  output logic [5:0] byte_index_o,
  output logic [7:0] payload_byte_o,
  output logic       has_payload_o,
  output logic       last_o
);
  import xcfp_pkg::*;

  // Index width of one payload bank; the bank bit sits above it.
  localparam int unsigned IdxW = (MAX_DATA_LEN > 1) ? $clog2(MAX_DATA_LEN) : 1;

  cfg_t        cfg_q;
  frame_desc_t push_desc;
  frame_desc_t head_desc;
  queue_stat_t q_stat;
  logic        q_push;
  logic        q_pop;
  logic        wr_en;
  logic [IdxW:0] wr_addr;
  logic [7:0]  wr_data;

  // Configuration registers. Values are taken at their register width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_header  <= FIRST_HEADER_RST;
      cfg_q.second_header <= SECOND_HEADER_RST;
      cfg_q.tail_byte     <= TAIL_BYTE_RST;
      cfg_q.max_payload   <= MAX_PAYLOAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FIRST_HEADER:  cfg_q.first_header  <= cfg_data_i;
        CFG_SECOND_HEADER: cfg_q.second_header <= cfg_data_i;
        CFG_TAIL_BYTE:     cfg_q.tail_byte     <= cfg_data_i;
        CFG_MAX_PAYLOAD:   cfg_q.max_payload   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // The front end parses the byte stream and fills the bank it owns.
  xcfp_front #(
    .MAX_DATA_LEN(MAX_DATA_LEN),
    .IdxW        (IdxW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .rx_byte_i (rx_byte_i),
    .q_stat_i  (q_stat),
    .push_o    (q_push),
    .desc_o    (push_desc),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data)
  );

  // One queue entry per accepted frame; an entry stays until its replay ends,
  // which keeps its bank from being overwritten.
  xcfp_queue u_queue (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(q_push),
    .desc_i(push_desc),
    .pop_i (q_pop),
    .head_o(head_desc),
    .stat_o(q_stat)
  );

  // The back end replays the frame at the queue head.
  xcfp_back #(
    .MAX_DATA_LEN(MAX_DATA_LEN),
    .IdxW        (IdxW)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_en_i         (wr_en),
    .wr_addr_i       (wr_addr),
    .wr_data_i       (wr_data),
    .head_i          (head_desc),
    .q_stat_i        (q_stat),
    .pop_o           (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .command_o       (command_o),
    .payload_length_o(payload_length_o),
    .byte_index_o    (byte_index_o),
    .payload_byte_o  (payload_byte_o),
    .has_payload_o   (has_payload_o),
    .last_o          (last_o)
  );

  // A frame is never committed while both banks are still owned by replay.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push |-> !q_stat.full)
    else $error("frame committed with both payload banks busy");

  // Replay only finishes a frame that is queued.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_pop |-> !q_stat.empty)
    else $error("replay finished with no frame queued");

  // An empty-frame result is a single, final result with zero data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !has_payload_o) |->
      (last_o && payload_byte_o == 8'd0 && byte_index_o == 6'd0 &&
       payload_length_o == 7'd0))
    else $error("malformed empty-frame result");

  // A frame is written into a bank only while the queue has room for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_en |-> !q_stat.full)
    else $error("payload write into a bank still under replay");

endmodule
